// ===== design/lec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lec_pkg;

  localparam int SAMPLE_FRAC_BITS = 12;
  localparam int ALPHA_FRAC_BITS  = 15;

  localparam int CURVE_PASSES = 8;
  localparam int PASS_IDX_W   = $clog2(CURVE_PASSES);
  localparam int MID_PASS     = 3;

  localparam int SAMPLE_W   = SAMPLE_FRAC_BITS + 1;
  localparam int ALPHA_W    = ALPHA_FRAC_BITS + 1;
  localparam int PROD_SHIFT = SAMPLE_FRAC_BITS + ALPHA_FRAC_BITS;

  // x*(x-ONE) from two (SAMPLE_W+1)-bit signed operands
  localparam int D_W = 2 * (SAMPLE_W + 1);
  localparam int P_W = D_W + ALPHA_W;
  localparam int Q_W = P_W - PROD_SHIFT;
  localparam int R_W = Q_W + 1;

  localparam logic [SAMPLE_W-1:0] UNIT_VALUE = SAMPLE_W'(1) << SAMPLE_FRAC_BITS;
  localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(1) <<< (PROD_SHIFT - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [ALPHA_W-1:0]  alpha_t;

  typedef struct packed {
    sample_t sample_in;
    alpha_t  alpha_one;
    alpha_t  alpha_two;
    alpha_t  alpha_three;
    alpha_t  alpha_four;
    alpha_t  alpha_five;
    alpha_t  alpha_six;
    alpha_t  alpha_seven;
    alpha_t  alpha_eight;
  } in_item_t;

  typedef struct packed {
    sample_t sample_mid;
    sample_t sample_out;
  } out_item_t;

  // Working item carried down the pipe: current sample, tap after pass four,
  // and the coefficients of every pass.
  typedef struct packed {
    sample_t                     x;
    sample_t                     mid;
    logic [CURVE_PASSES-1:0][ALPHA_W-1:0] alpha;
  } carry_t;

endpackage

`default_nettype wire

// ===== design/lec_pass.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lec_pass (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [lec_pkg::PASS_IDX_W-1:0] pass_sel,
  input  wire                             up_valid,
  output logic                            up_stall,
  input  wire  lec_pkg::carry_t           up_data,
  output logic                            dn_valid,
  input  wire                             dn_stall,
  output lec_pkg::carry_t                 dn_data
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  lec_pkg::carry_t c1_r, c1_nxt, c2_r, c3_r, c3_nxt;
  logic signed [lec_pkg::D_W-1:0] d_r, d_nxt;
  logic signed [lec_pkg::P_W-1:0] p_r, p_nxt;

  logic signed [lec_pkg::SAMPLE_W:0] xs, xm;
  logic signed [lec_pkg::P_W-1:0]    p_rnd;
  logic signed [lec_pkg::Q_W-1:0]    q;
  logic signed [lec_pkg::R_W-1:0]    r;
  lec_pkg::sample_t                  x_c, x_new;

  // A stage advances when it is empty or the stage below moves.
  assign adv3     = !v3_r || !dn_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_stall = !adv1;

  // Stage 1: clamp and form x*(x - ONE)
  always_comb begin
    x_c    = (up_data.x > lec_pkg::UNIT_VALUE) ? lec_pkg::UNIT_VALUE : up_data.x;
    xs     = $signed({1'b0, x_c});
    xm     = xs - $signed({1'b0, lec_pkg::UNIT_VALUE});
    d_nxt  = xs * xm;
    c1_nxt = up_data;
    c1_nxt.x = x_c;
  end

  // Stage 2: scale by this pass's coefficient
  assign p_nxt = d_r * $signed(c1_r.alpha[pass_sel]);

  // Stage 3: round to nearest, add, saturate to 0..ONE
  always_comb begin
    p_rnd = p_r + lec_pkg::ROUND_HALF;
    q     = p_rnd[lec_pkg::P_W-1:lec_pkg::PROD_SHIFT];
    r     = lec_pkg::R_W'($signed({1'b0, c2_r.x})) + lec_pkg::R_W'(q);
    if (r[lec_pkg::R_W-1]) begin
      x_new = '0;
    end else if (r > $signed(lec_pkg::R_W'(lec_pkg::UNIT_VALUE))) begin
      x_new = lec_pkg::UNIT_VALUE;
    end else begin
      x_new = r[lec_pkg::SAMPLE_W-1:0];
    end
    c3_nxt   = c2_r;
    c3_nxt.x = x_new;
    if (pass_sel == lec_pkg::PASS_IDX_W'(lec_pkg::MID_PASS)) begin
      c3_nxt.mid = x_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c1_r <= c1_nxt;
      d_r  <= d_nxt;
    end
    if (adv2) begin
      c2_r <= c1_r;
      p_r  <= p_nxt;
    end
    if (adv3) begin
      c3_r <= c3_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = c3_r;

endmodule

`default_nettype wire

// ===== design/light_enhance_curve_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Light-enhancement curve stack: applies x = x + a*(x*x - x) eight times to one
// colour sample, each pass with its own signed coefficient, and returns the
// sample after pass four (sample_mid) and after pass eight (sample_out).
// Input channel in_valid/in_stall/in_data carries the sample and eight
// coefficients; result channel out_valid/out_stall/out_data carries both taps.
// A transfer happens on a rising edge with valid high and stall low.
// Each of the eight passes has three register stages (square term, coefficient
// multiply, round and saturate). Throughput is one item per cycle while
// out_stall is low; the two multipliers of each pass set the stage split.
// Every stage has its own valid bit and moves when the stage below is empty or
// moving, so bubbles close up and a stalled receiver backs up the pipe one
// stage at a time; in_stall rises only when all 24 stages hold items.
// Synchronous reset (rst_n low) empties the pipe; no other state is kept.
module light_enhance_curve_stack (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire lec_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output lec_pkg::out_item_t      out_data
);

  logic            valid_l [lec_pkg::CURVE_PASSES+1];
  logic            stall_l [lec_pkg::CURVE_PASSES+1];
  lec_pkg::carry_t data_l  [lec_pkg::CURVE_PASSES+1];

  always_comb begin
    data_l[0]          = '0;
    data_l[0].x        = in_data.sample_in;
    data_l[0].alpha[0] = in_data.alpha_one;
    data_l[0].alpha[1] = in_data.alpha_two;
    data_l[0].alpha[2] = in_data.alpha_three;
    data_l[0].alpha[3] = in_data.alpha_four;
    data_l[0].alpha[4] = in_data.alpha_five;
    data_l[0].alpha[5] = in_data.alpha_six;
    data_l[0].alpha[6] = in_data.alpha_seven;
    data_l[0].alpha[7] = in_data.alpha_eight;
  end

  assign valid_l[0] = in_valid;
  assign in_stall   = stall_l[0];

  for (genvar k = 0; k < lec_pkg::CURVE_PASSES; k++) begin : g_pass
    lec_pass u_pass (
      .clk      (clk),
      .rst_n    (rst_n),
      .pass_sel (lec_pkg::PASS_IDX_W'(k)),
      .up_valid (valid_l[k]),
      .up_stall (stall_l[k]),
      .up_data  (data_l[k]),
      .dn_valid (valid_l[k+1]),
      .dn_stall (stall_l[k+1]),
      .dn_data  (data_l[k+1])
    );
  end

  assign stall_l[lec_pkg::CURVE_PASSES] = out_stall;
  assign out_valid           = valid_l[lec_pkg::CURVE_PASSES];
  assign out_data.sample_mid = data_l[lec_pkg::CURVE_PASSES].mid;
  assign out_data.sample_out = data_l[lec_pkg::CURVE_PASSES].x;

endmodule

`default_nettype wire

// ===== test/light_enhance_curve_stack_tb.sv =====
`timescale 1ns / 1ps

module light_enhance_curve_stack_tb;
  import lec_pkg::*;

  localparam longint UNIT        = longint'(1) <<< SAMPLE_FRAC_BITS;
  localparam longint ROUND_BIAS  = longint'(1) <<< (PROD_SHIFT - 1);
  localparam int     QUIET_TAIL  = 120;
  localparam int     DRAIN_WAIT  = 40;
  localparam int     STALL_LIMIT = 2000;
  localparam int     RANDOM_ITEMS = 1030;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  in_item_t  sample_q[$];
  out_item_t enhanced_q[$];
  int        fail_count = 0;
  int        gap_left = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  light_enhance_curve_stack uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Eight curve passes, each rounded to nearest (ties up) and clamped to 0..1.
  function automatic out_item_t enhance_sample(in_item_t it);
    longint    coef [CURVE_PASSES];
    longint    x;
    longint    d;
    longint    p;
    longint    q;
    out_item_t res;
    coef[0] = $signed(it.alpha_one);
    coef[1] = $signed(it.alpha_two);
    coef[2] = $signed(it.alpha_three);
    coef[3] = $signed(it.alpha_four);
    coef[4] = $signed(it.alpha_five);
    coef[5] = $signed(it.alpha_six);
    coef[6] = $signed(it.alpha_seven);
    coef[7] = $signed(it.alpha_eight);
    res = '0;
    x = longint'(it.sample_in);
    if (x > UNIT) x = UNIT;
    for (int k = 0; k < CURVE_PASSES; k++) begin
      d = x * x - x * UNIT;
      p = coef[k] * d;
      q = (p + ROUND_BIAS) >>> PROD_SHIFT;
      x = x + q;
      if (x < 0) x = 0;
      if (x > UNIT) x = UNIT;
      if (k == MID_PASS) res.sample_mid = sample_t'(x);
    end
    res.sample_out = sample_t'(x);
    return res;
  endfunction

  function automatic in_item_t flat_item(int s, int a);
    in_item_t it;
    it.sample_in   = sample_t'(s);
    it.alpha_one   = alpha_t'(a);
    it.alpha_two   = alpha_t'(a);
    it.alpha_three = alpha_t'(a);
    it.alpha_four  = alpha_t'(a);
    it.alpha_five  = alpha_t'(a);
    it.alpha_six   = alpha_t'(a);
    it.alpha_seven = alpha_t'(a);
    it.alpha_eight = alpha_t'(a);
    return it;
  endfunction

  function automatic alpha_t rand_alpha();
    case ($urandom_range(0, 3))
      0: return alpha_t'($urandom_range(0, 65535));
      1: return alpha_t'(int'($urandom_range(0, 1024)) - 512);
      2: begin
        case ($urandom_range(0, 3))
          0: return alpha_t'(32767);
          1: return alpha_t'(-32768);
          2: return '0;
          default: return '1;
        endcase
      end
      // odd multiple of 16: rounding ties whenever x*(x-1) is an odd multiple of 2^22
      default: return alpha_t'({$urandom_range(0, 2047), 5'b10000});
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    case ($urandom_range(0, 9))
      0: it.sample_in = sample_t'($urandom_range(4097, 8191));
      1: it.sample_in = $urandom_range(0, 1) ? sample_t'(0) : UNIT_VALUE;
      2: it.sample_in = sample_t'({$urandom_range(1, 15), 8'h00});
      default: it.sample_in = sample_t'($urandom_range(0, 4096));
    endcase
    it.alpha_one   = rand_alpha();
    it.alpha_two   = rand_alpha();
    it.alpha_three = rand_alpha();
    it.alpha_four  = rand_alpha();
    it.alpha_five  = rand_alpha();
    it.alpha_six   = rand_alpha();
    it.alpha_seven = rand_alpha();
    it.alpha_eight = rand_alpha();
    return it;
  endfunction

  // Driver: hold a stalled transfer, otherwise idle in bursts or present the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) enhanced_q.push_back(enhance_sample(in_data));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  always @(posedge clk) begin : monitor_proc
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (enhanced_q.size() == 0) begin
          $error("unexpected result transfer: sample_mid %0d, sample_out %0d",
                 out_data.sample_mid, out_data.sample_out);
          fail_count++;
        end else begin
          want = enhanced_q.pop_front();
          if (out_data.sample_mid !== want.sample_mid) begin
            $error("sample_mid: expected %0d, actual %0d", want.sample_mid,
                   out_data.sample_mid);
            fail_count++;
          end
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out,
                   out_data.sample_out);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (sample_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        hold_left <= $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;

    sample_q.push_back(flat_item(0, 0));
    sample_q.push_back(flat_item(4096, 0));
    sample_q.push_back(flat_item(8191, 0));
    sample_q.push_back(flat_item(4097, 32767));
    sample_q.push_back(flat_item(8191, -32768));
    sample_q.push_back(flat_item(2048, 32767));
    sample_q.push_back(flat_item(2048, -32768));
    sample_q.push_back(flat_item(1, -32768));
    sample_q.push_back(flat_item(1, 32767));
    sample_q.push_back(flat_item(4095, -32768));
    sample_q.push_back(flat_item(4095, 32767));
    sample_q.push_back(flat_item(4096, -32768));
    // exact halfway products at x = 0.5 in different passes
    it = flat_item(2048, 0);
    it.alpha_one = alpha_t'(16);
    sample_q.push_back(it);
    it.alpha_one = alpha_t'(-16);
    sample_q.push_back(it);
    it.alpha_one = alpha_t'(-32752);
    sample_q.push_back(it);
    it = flat_item(2048, 0);
    it.alpha_four = alpha_t'(-16);
    sample_q.push_back(it);
    it = flat_item(2048, 0);
    it.alpha_five = alpha_t'(16);
    sample_q.push_back(it);
    it = flat_item(2048, 0);
    it.alpha_eight = alpha_t'(48);
    sample_q.push_back(it);
    it = flat_item(3000, 32767);
    it.alpha_two  = alpha_t'(-32768);
    it.alpha_four = alpha_t'(-32768);
    it.alpha_six  = alpha_t'(-32768);
    it.alpha_eight = alpha_t'(-32768);
    sample_q.push_back(it);
    it = rand_item();
    it.sample_in = '0;
    sample_q.push_back(it);
    repeat (RANDOM_ITEMS) sample_q.push_back(rand_item());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || enhanced_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
